// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/mbph_pkg.sv =====
// Package for the meter ballistics block: sizes, register indexes and microcode.
// Depends on nothing; used by the core and by its checker.
package mbph_pkg;

	// Bar geometry.
	localparam int SEGMENTS = 16;
	localparam int SEG_W    = $clog2(SEGMENTS + 1);
	localparam int NUM_W    = 16 + $clog2(SEGMENTS) + 1;
	localparam int CNT_W    = $clog2(SEG_W + 1);

	// Register file.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FULL_SCALE = 3'd0,
		REG_ATTACK     = 3'd1,
		REG_RELEASE    = 3'd2,
		REG_HOLD       = 3'd3,
		REG_DECAY      = 3'd4
	} reg_idx_t;

	localparam logic [15:0] FULL_SCALE_RST = 16'd20480;
	localparam logic [7:0]  ATTACK_RST     = 8'd141;
	localparam logic [7:0]  RELEASE_RST    = 8'd41;
	localparam logic [7:0]  HOLD_RST       = 8'd45;
	localparam logic [7:0]  DECAY_RST      = 8'd31;

	// Datapath operations driven by the control word.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_WAIT,
		OP_DIFF,
		OP_MUL,
		OP_APPLY,
		OP_PEAK,
		OP_SEGINIT,
		OP_DIVSTEP,
		OP_SEGDONE,
		OP_OUT
	} op_t;

	// Jump conditions; when the condition is true the sequencer takes jump_pc.
	typedef enum logic [2:0] {
		C_NEVER,
		C_NO_REQ,
		C_NO_DECAY,
		C_CLAMP,
		C_DIV_MORE,
		C_OUT_BUSY
	} cond_t;

	// Operand select: smoothed level or held peak.
	typedef enum logic {
		SEL_LEVEL,
		SEL_PEAK
	} sel_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	typedef struct packed {
		op_t   op;
		sel_t  sel;
		cond_t cond;
		pc_t   jump_pc;
		pc_t   next_pc;
	} uword_t;

	// Step addresses of the program.
	localparam pc_t ST_WAIT      = 4'd0;
	localparam pc_t ST_L_DIFF    = 4'd1;
	localparam pc_t ST_L_MUL     = 4'd2;
	localparam pc_t ST_L_APPLY   = 4'd3;
	localparam pc_t ST_PEAK      = 4'd4;
	localparam pc_t ST_P_DIFF    = 4'd5;
	localparam pc_t ST_P_MUL     = 4'd6;
	localparam pc_t ST_P_APPLY   = 4'd7;
	localparam pc_t ST_L_SEGINIT = 4'd8;
	localparam pc_t ST_L_DIV     = 4'd9;
	localparam pc_t ST_L_SEGDONE = 4'd10;
	localparam pc_t ST_P_SEGINIT = 4'd11;
	localparam pc_t ST_P_DIV     = 4'd12;
	localparam pc_t ST_P_SEGDONE = 4'd13;
	localparam pc_t ST_OUT       = 4'd14;

	// Control store: one word per step.
	function automatic uword_t ucode_rom(pc_t pc);
		uword_t w;
		case (pc)
			ST_WAIT:      w = '{OP_WAIT,    SEL_LEVEL, C_NO_REQ,   ST_WAIT,      ST_L_DIFF};
			ST_L_DIFF:    w = '{OP_DIFF,    SEL_LEVEL, C_NEVER,    ST_WAIT,      ST_L_MUL};
			ST_L_MUL:     w = '{OP_MUL,     SEL_LEVEL, C_NEVER,    ST_WAIT,      ST_L_APPLY};
			ST_L_APPLY:   w = '{OP_APPLY,   SEL_LEVEL, C_NEVER,    ST_WAIT,      ST_PEAK};
			ST_PEAK:      w = '{OP_PEAK,    SEL_LEVEL, C_NO_DECAY, ST_L_SEGINIT, ST_P_DIFF};
			ST_P_DIFF:    w = '{OP_DIFF,    SEL_PEAK,  C_NEVER,    ST_WAIT,      ST_P_MUL};
			ST_P_MUL:     w = '{OP_MUL,     SEL_PEAK,  C_NEVER,    ST_WAIT,      ST_P_APPLY};
			ST_P_APPLY:   w = '{OP_APPLY,   SEL_PEAK,  C_NEVER,    ST_WAIT,      ST_L_SEGINIT};
			ST_L_SEGINIT: w = '{OP_SEGINIT, SEL_LEVEL, C_CLAMP,    ST_L_SEGDONE, ST_L_DIV};
			ST_L_DIV:     w = '{OP_DIVSTEP, SEL_LEVEL, C_DIV_MORE, ST_L_DIV,     ST_L_SEGDONE};
			ST_L_SEGDONE: w = '{OP_SEGDONE, SEL_LEVEL, C_NEVER,    ST_WAIT,      ST_P_SEGINIT};
			ST_P_SEGINIT: w = '{OP_SEGINIT, SEL_PEAK,  C_CLAMP,    ST_P_SEGDONE, ST_P_DIV};
			ST_P_DIV:     w = '{OP_DIVSTEP, SEL_PEAK,  C_DIV_MORE, ST_P_DIV,     ST_P_SEGDONE};
			ST_P_SEGDONE: w = '{OP_SEGDONE, SEL_PEAK,  C_NEVER,    ST_WAIT,      ST_OUT};
			ST_OUT:       w = '{OP_OUT,     SEL_LEVEL, C_OUT_BUSY, ST_OUT,       ST_WAIT};
			default:      w = '{OP_NOP,     SEL_LEVEL, C_NEVER,    ST_WAIT,      ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== sv/meter_ballistics_peak_hold_core.sv =====
// Bar-graph meter ballistics with peak hold: microcoded sequencer and datapath.
// Depends on mbph_pkg for sizes, register indexes and the control store.
//
// Usage: one request on the input channel (target_level, Q6.10 dB) is one
// display tick. The block answers each request with one result on the output
// channel: smoothed level, held peak, lit segment count and the peak marker.
// Both channels use valid/ready; a request or result moves when both are high.
// Steps of a tick, in order: level difference, gain product and update, peak
// test, then peak difference, product and update when the peak decays, a
// restoring division for each segment count that does not saturate at full
// scale, and the output step. One shared 8x24 multiplier and a one-bit-per-cycle
// restoring divider do the arithmetic for level and peak alike.
// The input is taken only at the wait step of the program; a finished result
// sits in the output register while the next request is already accepted and
// processed, so a stalled receiver only holds the sequencer at its last step.
// Reset (arst_n low) clears the level, peak and age to zero, loads the
// register defaults and empties the output register. Configuration writes
// take effect at once and are meant for idle periods.
module meter_ballistics_peak_hold_core
	import mbph_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [15:0]           target_level,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           level_out,
	output logic [15:0]           peak_out,
	output logic [4:0]            lit_count,
	output logic                  peak_visible,
	output logic [3:0]            peak_segment
);

	// Configuration registers.
	logic [15:0] full_scale_q;
	logic [7:0]  attack_q;
	logic [7:0]  release_q;
	logic [7:0]  hold_q;
	logic [7:0]  decay_q;

	// Architectural state and sequencer.
	logic [23:0] level_q;
	logic [23:0] peak_q;
	logic [7:0]  age_q;
	pc_t         pc_q;
	logic        out_valid_q;

	// Datapath scratch registers.
	logic [23:0]      target_q;
	logic [23:0]      diff_q;
	logic             up_q;
	logic [23:0]      step_q;
	logic [15:0]      rem_q;
	logic [SEG_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             clamp_q;
	logic [SEG_W-1:0] lit_q;
	logic [SEG_W-1:0] pk_q;

	uword_t uw;
	logic   cond_true;
	logic   out_free;

	logic [23:0]      from_val;
	logic [23:0]      to_val;
	logic             up_d;
	logic [23:0]      diff_d;
	logic [7:0]       coef;
	logic [31:0]      prod;
	logic [23:0]      apply_d;
	logic [7:0]       age_inc;
	logic             no_decay;
	logic [15:0]      seg_lv;
	logic [15:0]      range_v;
	logic             seg_clamp;
	logic [NUM_W-1:0] numer;
	logic [16:0]      trial;
	logic             trial_ge;
	logic [SEG_W-1:0] seg_res;
	logic             vis_d;

	assign uw       = ucode_rom(pc_q);
	assign in_ready = (uw.op == OP_WAIT);
	assign out_free = !out_valid_q || out_ready;

	// Operand selection for the smoothing steps.
	always_comb begin
		if (uw.sel == SEL_PEAK) begin
			from_val = peak_q;
			to_val   = level_q;
			coef     = decay_q;
		end else begin
			from_val = level_q;
			to_val   = target_q;
			coef     = up_q ? attack_q : release_q;
		end
	end

	// Distance and direction toward the goal.
	assign up_d   = to_val > from_val;
	assign diff_d = up_d ? (to_val - from_val) : (from_val - to_val);

	// Rounded gain product; at most the distance, so it never overshoots.
	assign prod    = (32'(coef) * 32'(diff_q)) + 32'd128;
	assign apply_d = up_q ? (from_val + step_q) : (from_val - step_q);

	// Peak age with saturation and the hold test.
	assign age_inc  = (age_q == 8'hFF) ? age_q : (age_q + 8'd1);
	assign no_decay = (level_q >= peak_q) || (age_inc <= hold_q);

	// Segment count: ceil(lv * SEGMENTS / range), saturated when lv reaches range.
	assign seg_lv    = (uw.sel == SEL_PEAK) ? peak_q[23:8] : level_q[23:8];
	assign range_v   = (full_scale_q == 16'd0) ? 16'd1 : full_scale_q;
	assign seg_clamp = seg_lv >= range_v;
	assign numer     = (NUM_W'(seg_lv) * NUM_W'(SEGMENTS)) + NUM_W'(range_v) - NUM_W'(1);

	// One restoring division step.
	assign trial    = {rem_q, quo_q[SEG_W-1]};
	assign trial_ge = trial >= {1'b0, range_v};

	always_comb begin
		if (clamp_q || (quo_q > SEG_W'(SEGMENTS))) begin
			seg_res = SEG_W'(SEGMENTS);
		end else begin
			seg_res = quo_q;
		end
	end

	assign vis_d = pk_q > lit_q;

	// Jump condition select.
	always_comb begin
		case (uw.cond)
			C_NEVER:    cond_true = 1'b0;
			C_NO_REQ:   cond_true = !in_valid;
			C_NO_DECAY: cond_true = no_decay;
			C_CLAMP:    cond_true = seg_clamp;
			C_DIV_MORE: cond_true = (cnt_q != CNT_W'(1));
			C_OUT_BUSY: cond_true = !out_free;
			default:    cond_true = 1'b0;
		endcase
	end

	// Step counter, state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q         <= ST_WAIT;
			out_valid_q  <= 1'b0;
			level_q      <= '0;
			peak_q       <= '0;
			age_q        <= '0;
			full_scale_q <= FULL_SCALE_RST;
			attack_q     <= ATTACK_RST;
			release_q    <= RELEASE_RST;
			hold_q       <= HOLD_RST;
			decay_q      <= DECAY_RST;
		end else begin
			pc_q <= cond_true ? uw.jump_pc : uw.next_pc;

			// A new result takes the register as the old one leaves it.
			if (uw.op == OP_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (uw.op == OP_APPLY) begin
				if (uw.sel == SEL_PEAK) begin
					peak_q <= apply_d;
				end else begin
					level_q <= apply_d;
				end
			end

			if (uw.op == OP_PEAK) begin
				if (level_q >= peak_q) begin
					peak_q <= level_q;
					age_q  <= '0;
				end else begin
					age_q <= age_inc;
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_FULL_SCALE: full_scale_q <= cfg_data;
					REG_ATTACK:     attack_q     <= cfg_data[7:0];
					REG_RELEASE:    release_q    <= cfg_data[7:0];
					REG_HOLD:       hold_q       <= cfg_data[7:0];
					REG_DECAY:      decay_q      <= cfg_data[7:0];
					default:        ;
				endcase
			end
		end
	end

	// Datapath scratch and output payload registers.
	always_ff @(posedge clk) begin
		case (uw.op)
			OP_WAIT: begin
				if (in_valid) begin
					target_q <= {target_level, 8'd0};
				end
			end
			OP_DIFF: begin
				diff_q <= diff_d;
				up_q   <= up_d;
			end
			OP_MUL: begin
				step_q <= prod[31:8];
			end
			OP_SEGINIT: begin
				clamp_q <= seg_clamp;
				rem_q   <= 16'(numer >> SEG_W);
				quo_q   <= numer[SEG_W-1:0];
				cnt_q   <= CNT_W'(SEG_W);
			end
			OP_DIVSTEP: begin
				rem_q <= trial_ge ? 16'(trial - {1'b0, range_v}) : trial[15:0];
				quo_q <= {quo_q[SEG_W-2:0], trial_ge};
				cnt_q <= cnt_q - CNT_W'(1);
			end
			OP_SEGDONE: begin
				if (uw.sel == SEL_PEAK) begin
					pk_q <= seg_res;
				end else begin
					lit_q <= seg_res;
				end
			end
			OP_OUT: begin
				if (out_free) begin
					level_out    <= level_q[23:8];
					peak_out     <= peak_q[23:8];
					lit_count    <= 5'(lit_q);
					peak_visible <= vis_d;
					peak_segment <= vis_d ? 4'(pk_q - SEG_W'(1)) : 4'd0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/mbph_checker.sv =====
// Port-level checker for the meter ballistics core, bound to the core module.
// Depends on mbph_pkg and on the macros in assert_macros.svh.
`include "assert_macros.svh"

module mbph_checker
	import mbph_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] level_out,
	input logic [15:0] peak_out,
	input logic [4:0]  lit_count,
	input logic        peak_visible,
	input logic [3:0]  peak_segment
);

	// A stalled result keeps its level, peak and lit count.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(level_out) && $stable(peak_out) && $stable(lit_count))

	// The lit count never exceeds the bar length.
	`ASSERT_ALWAYS(a_lit_range, clk, arst_n, !out_valid || (lit_count <= 5'(SEGMENTS)))

	// A hidden marker reports segment zero.
	`ASSERT_ALWAYS(a_hidden_seg, clk, arst_n, !out_valid || peak_visible || (peak_segment == 4'd0))

	// A visible marker sits above the lit segments, and the peak is at least the level.
	`ASSERT_ALWAYS(a_marker_above, clk, arst_n, !out_valid || !peak_visible || ((5'(peak_segment) >= lit_count) && (peak_out >= level_out)))

endmodule

bind meter_ballistics_peak_hold_core mbph_checker u_mbph_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.level_out    (level_out),
	.peak_out     (peak_out),
	.lit_count    (lit_count),
	.peak_visible (peak_visible),
	.peak_segment (peak_segment)
);

// ===== tb/tb_meter_ballistics_peak_hold_core.sv =====
// Self-checking testbench for meter_ballistics_peak_hold_core: level smoothing,
// peak hold and decay, and bar segment mapping, under random handshake pressure.
// Depends on mbph_pkg and the core; a scoreboard class predicts every display tick.
`timescale 1ns / 1ps

module tb_meter_ballistics_peak_hold_core;
	import mbph_pkg::*;

	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	// One display frame as the block reports it.
	typedef struct packed {
		logic [15:0] level;
		logic [15:0] peak;
		logic [4:0]  lit;
		logic        visible;
		logic [3:0]  seg;
	} display_t;

	// Tracks the meter state and queues the frames the block must produce.
	class ballistics_scoreboard;
		logic [15:0] full_scale;
		logic [7:0]  attack_gain;
		logic [7:0]  release_gain;
		logic [7:0]  hold_count;
		logic [7:0]  decay_gain;
		logic [23:0] level_acc;
		logic [23:0] peak_acc;
		logic [7:0]  peak_age;
		display_t    pending_frames[$];
		int          errors;

		function new();
			full_scale   = FULL_SCALE_RST;
			attack_gain  = ATTACK_RST;
			release_gain = RELEASE_RST;
			hold_count   = HOLD_RST;
			decay_gain   = DECAY_RST;
			level_acc    = '0;
			peak_acc     = '0;
			peak_age     = '0;
			errors       = 0;
		endfunction

		// Register writes keep only the low byte for gain and hold; unknown indexes do nothing.
		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
			case (idx)
				REG_FULL_SCALE: full_scale   = data;
				REG_ATTACK:     attack_gain  = data[7:0];
				REG_RELEASE:    release_gain = data[7:0];
				REG_HOLD:       hold_count   = data[7:0];
				REG_DECAY:      decay_gain   = data[7:0];
				default: ;
			endcase
		endfunction

		// Moves a Q6.18 value toward a goal by gain/256 of the gap, rounded half up.
		function logic [23:0] glide(logic [23:0] from, logic [23:0] goal, logic [7:0] gain);
			logic [23:0] gap;
			logic [32:0] stride;
			gap = (goal >= from) ? goal - from : from - goal;
			stride = (33'(gain) * 33'(gap) + 33'd128) >> 8;
			return (goal >= from) ? from + stride[23:0] : from - stride[23:0];
		endfunction

		// Segments lit by a Q6.10 level, rounded up and clamped to the bar length.
		function int unsigned segments_for(logic [15:0] lvl);
			longint unsigned span;
			longint unsigned k;
			span = (full_scale == 16'd0) ? 64'd1 : 64'(full_scale);
			k = (64'(lvl) * 64'(SEGMENTS) + span - 64'd1) / span;
			if (k > 64'(SEGMENTS))
				k = 64'(SEGMENTS);
			return int'(k);
		endfunction

		// Advances the meter by one accepted request and queues the frame it yields.
		function void log_tick(logic [15:0] target);
			logic [23:0]  goal;
			display_t     frame;
			int unsigned  lit_n;
			int unsigned  peak_n;
			goal = {target, 8'd0};
			if (goal > level_acc)
				level_acc = glide(level_acc, goal, attack_gain);
			else
				level_acc = glide(level_acc, goal, release_gain);

			// The peak rides the level up; below it, it waits out the hold, then decays.
			if (level_acc >= peak_acc) begin
				peak_acc = level_acc;
				peak_age = '0;
			end else begin
				if (peak_age != 8'd255)
					peak_age = peak_age + 8'd1;
				if (peak_age > hold_count)
					peak_acc = glide(peak_acc, level_acc, decay_gain);
			end

			frame.level   = level_acc[23:8];
			frame.peak    = peak_acc[23:8];
			lit_n         = segments_for(frame.level);
			peak_n        = segments_for(frame.peak);
			frame.lit     = lit_n[4:0];
			frame.visible = peak_n > lit_n;
			frame.seg     = frame.visible ? 4'(peak_n - 1) : 4'd0;
			pending_frames.push_back(frame);
		endfunction

		function void check_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		// Compares one frame from the block against the oldest prediction.
		function void check_display(display_t got);
			display_t want;
			if (pending_frames.size() == 0) begin
				$error("frame with no request waiting: level_out %0d", got.level);
				errors++;
				return;
			end
			want = pending_frames.pop_front();
			check_field("level_out", want.level, got.level);
			check_field("peak_out", want.peak, got.peak);
			check_field("lit_count", want.lit, got.lit);
			check_field("peak_visible", want.visible, got.visible);
			check_field("peak_segment", want.seg, got.seg);
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [15:0]           target_level;
	logic                  out_valid;
	logic                  out_ready;
	logic [15:0]           level_out;
	logic [15:0]           peak_out;
	logic [4:0]            lit_count;
	logic                  peak_visible;
	logic [3:0]            peak_segment;

	ballistics_scoreboard board;
	bit                   no_idle;
	bit                   gaps_on;
	int                   ticks_sent;
	int                   quiet_cycles;
	int                   stall_left;
	int                   clean_left;

	// Directed opening at reset settings: start-up from zero, full range, boundaries.
	logic [15:0] opening_ticks [24] = '{
		16'd0, 16'd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
		16'd20480, 16'd20479, 16'd20481, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0,
		16'd0, 16'd0, 16'd1024, 16'd32768, 16'h5555, 16'hAAAA, 16'd19200,
		16'd1280, 16'd1281
	};

	meter_ballistics_peak_hold_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.target_level (target_level),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.level_out    (level_out),
		.peak_out     (peak_out),
		.lit_count    (lit_count),
		.peak_visible (peak_visible),
		.peak_segment (peak_segment)
	);

	always #5 clk = ~clk;

	// Receiver: alternates clean stretches with random stall bursts.
	always @(negedge clk) begin
		if (!no_idle && stall_left == 0 && clean_left == 0) begin
			if ($urandom_range(0, 9) == 0)
				clean_left = $urandom_range(20, 200);
			else if ($urandom_range(0, 2) == 0)
				stall_left = $urandom_range(1, 16);
		end
		if (!no_idle && stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left--;
		end else begin
			out_ready <= 1'b1;
			if (clean_left > 0)
				clean_left--;
		end
	end

	// Every frame that moves is checked against the prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_display(display_t'{level_out, peak_out, lit_count,
				peak_visible, peak_segment});
	end

	// Ends the run when no request or frame has moved for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** meter_ballistics_peak_hold_core: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		board.set_reg(idx, data);
	endtask

	// Presents one request, holds it until taken, then maybe leaves a gap.
	task automatic feed(input logic [15:0] value);
		int gap;
		@(negedge clk);
		in_valid     <= 1'b1;
		target_level <= value;
		do
			@(posedge clk);
		while (!in_ready);
		board.log_tick(value);
		ticks_sent++;
		if (!no_idle && gaps_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drains the block so the registers can be changed while it is idle.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random meter traffic: steady tones, bursts with long silences, ramps, noise.
	task automatic run_traffic(input int count);
		int start;
		int lim;
		int v;
		int stride;
		int len;
		start = ticks_sent;
		lim = board.full_scale + board.full_scale / 4;
		if (lim < 2048)
			lim = 2048;
		if (lim > 65535)
			lim = 65535;
		while (ticks_sent - start < count) begin
			gaps_on = $urandom_range(0, 1);
			case ($urandom_range(0, 4))
				0: begin
					v = $urandom_range(0, lim);
					repeat ($urandom_range(1, 40)) feed(16'(v));
				end
				1: begin
					// A burst followed by a quiet stretch lets the hold expire.
					v = $urandom_range(lim / 2, lim);
					repeat ($urandom_range(1, 8)) feed(16'(v));
					v = $urandom_range(0, lim / 8);
					len = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
						: $urandom_range(10, 80);
					repeat (len) feed(16'(v));
				end
				2: begin
					v = $urandom_range(0, lim);
					stride = int'($urandom_range(0, 2048)) - 1024;
					repeat ($urandom_range(5, 40)) begin
						feed(16'(v));
						v = v + stride;
						if (v < 0)
							v = 0;
						if (v > 65535)
							v = 65535;
					end
				end
				3: repeat ($urandom_range(1, 30)) feed(16'($urandom_range(0, 65535)));
				default: repeat ($urandom_range(1, 30)) feed(16'($urandom_range(0, lim)));
			endcase
		end
	endtask

	// Random settings with junk in the unused upper bits and a stray index write.
	task automatic load_random_settings();
		int unsigned raw;
		if ($urandom_range(0, 3) == 0)
			program_reg(REG_FULL_SCALE, 16'($urandom_range(0, 65535)));
		else
			program_reg(REG_FULL_SCALE, 16'($urandom_range(1024, 40000)));
		program_reg(REG_ATTACK, 16'($urandom_range(0, 65535)));
		program_reg(REG_RELEASE, 16'($urandom_range(0, 65535)));
		program_reg(REG_DECAY, 16'($urandom_range(0, 65535)));
		raw = ($urandom_range(0, 255) << 8) |
			(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20));
		program_reg(REG_HOLD, 16'(raw));
		program_reg(CFG_IDX_W'(REG_DECAY + $urandom_range(1, 3)),
			16'($urandom_range(0, 65535)));
	endtask

	initial begin
		board        = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_FULL_SCALE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		target_level = '0;
		out_ready    = 1'b0;
		no_idle      = 1'b0;
		gaps_on      = 1'b0;
		ticks_sent   = 0;
		quiet_cycles = 0;
		stall_left   = 0;
		clean_left   = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings.
		foreach (opening_ticks[i])
			feed(opening_ticks[i]);
		run_traffic(150);
		settle();

		// Zero full scale, fastest gains, no hold.
		program_reg(REG_FULL_SCALE, 16'd0);
		program_reg(REG_ATTACK, 16'h00FF);
		program_reg(REG_RELEASE, 16'h00FF);
		program_reg(REG_HOLD, 16'h0000);
		program_reg(REG_DECAY, 16'h00FF);
		run_traffic(150);
		settle();

		// Zero gains freeze the meter; a hold of 255 never expires.
		program_reg(REG_FULL_SCALE, 16'hFFFF);
		program_reg(REG_ATTACK, 16'h0000);
		program_reg(REG_RELEASE, 16'h0000);
		program_reg(REG_HOLD, 16'h00FF);
		program_reg(REG_DECAY, 16'h0000);
		run_traffic(60);
		settle();

		// Small full scale, slowest nonzero attack and release; upper data bits must be dropped.
		program_reg(REG_FULL_SCALE, 16'd1024);
		program_reg(REG_ATTACK, 16'hFF01);
		program_reg(REG_RELEASE, 16'hAA01);
		program_reg(REG_HOLD, 16'h55FE);
		program_reg(REG_DECAY, 16'h0080);
		program_reg(CFG_IDX_W'(REG_DECAY + 3), 16'hFFFF);
		run_traffic(150);
		settle();

		// Random settings; the last phase runs without any idling.
		for (int phase = 0; phase < 5; phase++) begin
			if (phase == 4)
				no_idle = 1'b1;
			load_random_settings();
			run_traffic(170);
			settle();
		end

		if (board.pending_frames.size() != 0) begin
			$error("%0d expected frames never arrived", board.pending_frames.size());
			board.errors++;
		end
		if (board.errors == 0)
			$display("** meter_ballistics_peak_hold_core: PASSED **");
		else
			$display("** meter_ballistics_peak_hold_core: FAILED **");
		$finish;
	end

endmodule
